// ----- design/dtwc_pkg.sv -----
package dtwc_pkg;

  localparam int unsigned LINES_DEF     = 32;
  localparam int unsigned ADDR_BITS_DEF = 32;
  localparam int unsigned ADDR_W        = 32;
  localparam int unsigned CNT_W         = 32;
  localparam int unsigned OUT_TDATA_W   = 72;

  typedef struct packed {
    logic clear;
    logic accept;
    logic update;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_block;
  } ctrl_stat_t;

endpackage

// ----- design/dtwc_ram.sv -----
module dtwc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/dtwc_ctrl.sv -----
module dtwc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  dtwc_pkg::ctrl_stat_t  stat_i,
  output dtwc_pkg::ctrl_cmd_t   cmd_o
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_LOOK  = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    in_ready_o    = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (stat_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_LOOK;
        end
      end
      S_LOOK: begin
        if (!stat_i.out_block) begin
          cmd_o.update = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  a_clear_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR && stat_i.clr_last) |=> state_q == S_IDLE)
    else $error("clear pass did not hand over to idle");

  a_update_follows_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.update |-> ($past(cmd_o.accept) || $past(state_q) == S_LOOK))
    else $error("update without a pending transaction");

endmodule

// ----- design/dtwc_dp.sv -----
module dtwc_dp #(
  parameter int unsigned LINES     = dtwc_pkg::LINES_DEF,
  parameter int unsigned ADDR_BITS = dtwc_pkg::ADDR_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  dtwc_pkg::ctrl_cmd_t              cmd_i,
  output dtwc_pkg::ctrl_stat_t             stat_o,
  input  logic [dtwc_pkg::ADDR_W-1:0]      in_addr_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             out_direct_hit_o,
  output logic                             out_two_way_hit_o,
  output logic [dtwc_pkg::CNT_W-1:0]       out_total_hits_o,
  output logic [dtwc_pkg::CNT_W-1:0]       out_total_accesses_o
);

  localparam int unsigned LB    = $clog2(LINES);
  localparam int unsigned SB    = LB - 1;
  localparam int unsigned SETS  = LINES / 2;
  localparam int unsigned TAG_W = (ADDR_BITS > LB) ? ADDR_BITS - LB : 1;
  localparam int unsigned ENT_W = TAG_W + 1;
  localparam int unsigned ROW_W = 2 * ENT_W + 1;
  localparam int unsigned CW    = dtwc_pkg::CNT_W;
  localparam logic [63:0] AM64  = (64'd1 << ADDR_BITS) - 64'd1;
  localparam logic [dtwc_pkg::ADDR_W-1:0] AMASK = AM64[dtwc_pkg::ADDR_W-1:0];

  logic [dtwc_pkg::ADDR_W-1:0] in_m;
  logic [dtwc_pkg::ADDR_W-1:0] addr_q;
  logic [LB-1:0]               clr_q;
  logic [TAG_W-1:0]            tag;
  logic [LB-1:0]               line;
  logic [SB-1:0]               set_idx;

  logic [ENT_W-1:0] d_rdata, d_wdata;
  logic [ROW_W-1:0] s_rdata, s_wdata;
  logic [LB-1:0]    d_waddr;
  logic [SB-1:0]    s_waddr;
  logic             ram_we;

  logic             dhit, hit0, hit1, ahit, lru, fill_way;
  logic [ENT_W-1:0] way0_n, way1_n;
  logic [1:0]       nhits;
  logic [CW:0]      hsum, asum;

  logic          out_valid_q;
  logic          dhit_q, ahit_q;
  logic [CW-1:0] hits_q, acc_q;

  assign in_m    = in_addr_i & AMASK;
  assign tag     = TAG_W'((addr_q & AMASK) >> LB);
  assign line    = addr_q[LB-1:0];
  assign set_idx = addr_q[LB-1:1];

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      addr_q <= in_m;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  assign dhit = d_rdata[TAG_W] && (d_rdata[TAG_W-1:0] == tag);
  assign hit0 = s_rdata[TAG_W] && (s_rdata[TAG_W-1:0] == tag);
  assign hit1 = s_rdata[ENT_W+TAG_W] && (s_rdata[ENT_W+TAG_W-1:ENT_W] == tag);
  assign ahit = hit0 || hit1;
  assign lru  = s_rdata[ROW_W-1];

  always_comb begin
    way0_n   = s_rdata[ENT_W-1:0];
    way1_n   = s_rdata[2*ENT_W-1:ENT_W];
    fill_way = lru;
    if (hit0) begin
      fill_way = 1'b1;
    end else if (hit1) begin
      fill_way = 1'b0;
    end else begin
      fill_way = ~lru;
      if (lru) begin
        way1_n = {1'b1, tag};
      end else begin
        way0_n = {1'b1, tag};
      end
    end
  end

  assign ram_we  = cmd_i.clear || cmd_i.update;
  assign d_waddr = cmd_i.clear ? clr_q : line;
  assign s_waddr = cmd_i.clear ? clr_q[SB-1:0] : set_idx;
  assign d_wdata = cmd_i.clear ? '0 : {1'b1, tag};
  assign s_wdata = cmd_i.clear ? '0 : {fill_way, way1_n, way0_n};

  dtwc_ram #(.WIDTH(ENT_W), .DEPTH(LINES)) u_direct_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (d_waddr),
    .wdata_i (d_wdata),
    .re_i    (cmd_i.accept),
    .raddr_i (in_m[LB-1:0]),
    .rdata_o (d_rdata)
  );

  dtwc_ram #(.WIDTH(ROW_W), .DEPTH(SETS)) u_set_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .re_i    (cmd_i.accept),
    .raddr_i (in_m[LB-1:1]),
    .rdata_o (s_rdata)
  );

  assign nhits = {1'b0, dhit} + {1'b0, ahit};
  assign hsum  = {1'b0, hits_q} + (CW+1)'(nhits);
  assign asum  = {1'b0, acc_q} + (CW+1)'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      hits_q      <= '0;
      acc_q       <= '0;
    end else begin
      if (cmd_i.update) begin
        out_valid_q <= 1'b1;
        hits_q      <= hsum[CW] ? '1 : hsum[CW-1:0];
        acc_q       <= asum[CW] ? '1 : asum[CW-1:0];
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      dhit_q <= dhit;
      ahit_q <= ahit;
    end
  end

  assign stat_o.clr_last  = &clr_q;
  assign stat_o.out_block = out_valid_q && !out_ready_i;

  assign out_valid_o          = out_valid_q;
  assign out_direct_hit_o     = dhit_q;
  assign out_two_way_hit_o    = ahit_q;
  assign out_total_hits_o     = hits_q;
  assign out_total_accesses_o = acc_q;

  a_hits_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, hits_q} <= {acc_q, 1'b0})
    else $error("hit count exceeds two per transaction");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.update |-> !(out_valid_q && !out_ready_i))
    else $error("result overwritten before it was taken");

endmodule

// ----- design/direct_and_two_way_cache_hit_model.sv -----
// channel  | direction | tdata fields (lsb first)
// s_axis   | in        | address[31:0]
// m_axis   | out       | direct_hit, two_way_hit, total_hits[31:0], total_accesses[31:0]
//
// each transaction does one tag ram read, then compare and write back
// after reset a clearing pass sweeps the tag rams before s_axis_tready rises
// a result waits in the output register; the next address is taken meanwhile
// a second result stalls in the compare cycle while m_axis_tready is low
module direct_and_two_way_cache_hit_model #(
  parameter int unsigned LINES     = dtwc_pkg::LINES_DEF,
  parameter int unsigned ADDR_BITS = dtwc_pkg::ADDR_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [dtwc_pkg::ADDR_W-1:0]         s_axis_tdata,   // address
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [dtwc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata    // direct_hit, two_way_hit,
                                                              // total_hits, total_accesses, pad
);

  dtwc_pkg::ctrl_cmd_t  cmd;
  dtwc_pkg::ctrl_stat_t stat;

  logic                         dhit, ahit;
  logic [dtwc_pkg::CNT_W-1:0]   hits, accs;

  dtwc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  dtwc_dp #(.LINES(LINES), .ADDR_BITS(ADDR_BITS)) u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .stat_o               (stat),
    .in_addr_i            (s_axis_tdata),
    .out_valid_o          (m_axis_tvalid),
    .out_ready_i          (m_axis_tready),
    .out_direct_hit_o     (dhit),
    .out_two_way_hit_o    (ahit),
    .out_total_hits_o     (hits),
    .out_total_accesses_o (accs)
  );

  assign m_axis_tdata = {6'd0, accs, hits, ahit, dhit};

endmodule
